FILE: hw/rtl/atms_pkg.sv
package atms_pkg;

  // Fixed field widths
  localparam int unsigned RAW_W     = 13;
  localparam int unsigned OP_W      = RAW_W + 1;
  localparam int unsigned GAIN_W    = 40;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = GAIN_W + OP_W + 1;

  // Offset correction and 4-20 mA constants
  localparam logic [RAW_W-1:0] LOW_CUT    = 13'h0100;
  localparam logic [RAW_W-1:0] LOOP_FLOOR = 13'h0199;
  localparam logic [RAW_W-1:0] RAW_MAX    = 13'h1FFF;
  localparam logic [RAW_W-1:0] LOW_SUB    = 13'd2;
  localparam logic [RAW_W-1:0] HIGH_ADD   = 13'd3;

  // Scale modes; the unused code scales as linear
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_DOUBLE = 2'd1;
  localparam logic [1:0] MODE_LOOP   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd3;

  // Register reset values
  localparam logic [1:0]        RST_SCALE_MODE  = MODE_LOOP;
  localparam logic [GAIN_W-1:0] RST_GAIN        = 40'd167772;
  localparam logic [VAL_W-1:0]  RST_LOWER_LIMIT = 32'd0;
  localparam logic [VAL_W-1:0]  RST_UPPER_LIMIT = 32'd1048576;

endpackage

FILE: hw/rtl/atms_if.sv
// Sample request channel
interface atms_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result request channel
interface atms_out_if ();
  import atms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [RAW_W-1:0]        raw_mean;
  logic signed [VAL_W-1:0] scaled_value;
  logic                    clipped;

  modport source (output valid, output raw_mean, output scaled_value, output clipped,
                  input ready);
  modport sink   (input valid, input raw_mean, input scaled_value, input clipped,
                  output ready);
endinterface

// Register write channel
interface atms_cfg_if ();
  import atms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/adc_trimmed_mean_scaler.sv
// Trimmed-mean filter with linear / 4-20 mA scaling for one converter channel.
//
// Channels: in_i carries one sample per request, out_o one result per full
// frame of SAMPLES_PER_FRAME samples, cfg_i writes the four registers
// (scale mode, gain, lower limit, upper limit) and is always ready. Write the
// registers only while no frame result is pending.
//
// Throughput: one sample per cycle while in_i is ready. The sample path is a
// running max / min / sum update; each frame then flows through a four-stage
// pipeline (frame register, trimmed mean, gain multiply, round / offset / clip).
// The result of a frame passes through the frame, trimmed-mean, multiply and
// output registers in turn before it is valid on out_o.
//
// Reset: registers take their defaults, the frame accumulators clear and the
// pipeline empties.
// Stall: while out_o is held off, the pipeline stages fill up behind the
// output register; in_i drops ready only when the frame register cannot move
// on, so a stalled receiver stops samples only once four frame results are held.
module adc_trimmed_mean_scaler #(
  parameter int unsigned SAMPLES_PER_FRAME = 10,
  parameter int unsigned MEAN_SHIFT        = 3,
  parameter int unsigned SAMPLE_BITS       = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  atms_in_if.sink        in_i,
  atms_out_if.source     out_o,
  atms_cfg_if.sink       cfg_i
);
  import atms_pkg::*;

  localparam int unsigned CNT_W  = $clog2(SAMPLES_PER_FRAME);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(SAMPLES_PER_FRAME);
  localparam int unsigned MEAN_W = (SUM_W + 1 > RAW_W + 1) ? SUM_W + 1 : RAW_W + 1;
  localparam int unsigned ACC_W  = PROD_W - 8;

  // ---------------------------------------------------------------- config
  logic [1:0]               scale_mode_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic signed [VAL_W-1:0]  lower_limit_q;
  logic signed [VAL_W-1:0]  upper_limit_q;

  assign cfg_i.ready = 1'b1;

  // Take register writes; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mode_q  <= RST_SCALE_MODE;
      gain_q        <= RST_GAIN;
      lower_limit_q <= RST_LOWER_LIMIT;
      upper_limit_q <= RST_UPPER_LIMIT;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SCALE_MODE:  scale_mode_q  <= cfg_i.data[1:0];
        CFG_GAIN:        gain_q        <= cfg_i.data;
        CFG_LOWER_LIMIT: lower_limit_q <= cfg_i.data[VAL_W-1:0];
        CFG_UPPER_LIMIT: upper_limit_q <= cfg_i.data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- pipeline control
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy     = !out_v_q || out_o.ready;
  assign s3_rdy      = !s3_v_q || out_rdy;
  assign s2_rdy      = !s2_v_q || s3_rdy;
  assign s1_rdy      = !s1_v_q || s2_rdy;
  assign in_i.ready  = s1_rdy;

  // ----------------------------------------------------- frame accumulators
  logic [CNT_W-1:0]       cnt_q;
  logic [SAMPLE_BITS-1:0] max_q, min_q, max_d, min_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   in_acc, frame_last;

  assign in_acc     = in_i.valid && in_i.ready;
  assign frame_last = (cnt_q == CNT_W'(SAMPLES_PER_FRAME - 1));

  // Fold the new sample into the running max, min and sum
  always_comb begin
    if (cnt_q == '0) begin
      max_d = in_i.sample;
      min_d = in_i.sample;
      sum_d = SUM_W'(in_i.sample);
    end else begin
      max_d = (in_i.sample > max_q) ? in_i.sample : max_q;
      min_d = (in_i.sample < min_q) ? in_i.sample : min_q;
      sum_d = sum_q + SUM_W'(in_i.sample);
    end
  end

  // Advance the frame; clear it after the last sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      max_q <= '0;
      min_q <= '0;
      sum_q <= '0;
    end else if (in_acc) begin
      if (frame_last) begin
        cnt_q <= '0;
        max_q <= '0;
        min_q <= '0;
        sum_q <= '0;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
        max_q <= max_d;
        min_q <= min_d;
        sum_q <= sum_d;
      end
    end
  end

  // ----------------------------------------------------- stage 1: frame reg
  logic [SAMPLE_BITS-1:0] s1_max_q, s1_min_q;
  logic [SUM_W-1:0]       s1_sum_q;
  logic                   s1_load;

  assign s1_load = in_acc && frame_last;

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_max_q <= max_d;
      s1_min_q <= min_d;
      s1_sum_q <= sum_d;
    end
  end

  // ------------------------------------------------ stage 2: trimmed mean
  logic [SUM_W-1:0]  rest;
  logic [MEAN_W-1:0] mean_sh, mean_adj;
  logic [RAW_W-1:0]  raw_d, code_loop;
  logic [OP_W-1:0]   op_d;
  logic [RAW_W-1:0]  s2_raw_q;
  logic [OP_W-1:0]   s2_op_q;

  // Drop one max and one min (just one if the frame is flat), shift, then offset and clamp
  always_comb begin
    rest = s1_sum_q - SUM_W'(s1_max_q);
    if (s1_max_q != s1_min_q) begin
      rest = rest - SUM_W'(s1_min_q);
    end
    mean_sh = MEAN_W'(rest >> MEAN_SHIFT);
    if (mean_sh <= MEAN_W'(LOW_CUT)) begin
      mean_adj = (mean_sh >= MEAN_W'(LOW_SUB)) ? mean_sh - MEAN_W'(LOW_SUB) : '0;
    end else begin
      mean_adj = mean_sh + MEAN_W'(HIGH_ADD);
    end
    raw_d = (mean_adj > MEAN_W'(RAW_MAX)) ? RAW_MAX : mean_adj[RAW_W-1:0];

    // Select the multiplier operand by mode
    code_loop = (raw_d < LOOP_FLOOR) ? '0 : raw_d - LOOP_FLOOR;
    case (scale_mode_q)
      MODE_DOUBLE: op_d = {raw_d, 1'b0};
      MODE_LOOP:   op_d = {1'b0, code_loop};
      default:     op_d = {1'b0, raw_d};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_rdy) begin
      s2_raw_q <= raw_d;
      s2_op_q  <= op_d;
    end
  end

  // --------------------------------------------------- stage 3: multiply
  logic signed [PROD_W-1:0] prod_d, s3_prod_q;
  logic [RAW_W-1:0]         s3_raw_q;

  assign prod_d = gain_q * $signed({1'b0, s2_op_q});

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s3_rdy) begin
      s3_raw_q  <= s2_raw_q;
      s3_prod_q <= prod_d;
    end
  end

  // ------------------------------------------ stage 4: round, offset, clip
  logic signed [PROD_W-1:0] offs, acc;
  logic signed [ACC_W-1:0]  val, upper_ext, min_ext;
  logic signed [VAL_W-1:0]  scaled_d;
  logic                     clip_d;
  logic [RAW_W-1:0]         out_raw_q;
  logic signed [VAL_W-1:0]  out_val_q;
  logic                     out_clip_q;

  // Lower limit sits above the rounding half so one add does both
  always_comb begin
    offs      = {{(PROD_W - VAL_W - 8){lower_limit_q[VAL_W-1]}}, lower_limit_q, 8'h80};
    acc       = s3_prod_q + offs;
    val       = acc[PROD_W-1:8];
    upper_ext = {{(ACC_W - VAL_W){upper_limit_q[VAL_W-1]}}, upper_limit_q};
    min_ext   = {{(ACC_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};
    clip_d    = 1'b0;
    if (val > upper_ext) begin
      scaled_d = upper_limit_q;
      clip_d   = 1'b1;
    end else if (val < min_ext) begin
      scaled_d = min_ext[VAL_W-1:0];
    end else begin
      scaled_d = val[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && out_rdy) begin
      out_raw_q  <= s3_raw_q;
      out_val_q  <= scaled_d;
      out_clip_q <= clip_d;
    end
  end

  // Move stage valids along the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q  <= s1_load;
      if (s2_rdy) s2_v_q  <= s1_v_q;
      if (s3_rdy) s3_v_q  <= s2_v_q;
      if (out_rdy) out_v_q <= s3_v_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.raw_mean     = out_raw_q;
  assign out_o.scaled_value = out_val_q;
  assign out_o.clipped      = out_clip_q;

  // ------------------------------------------------------------ assertions
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SAMPLES_PER_FRAME - 1))
    else $error("sample count past end of frame");

  a_frame_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_last) |=> s1_v_q)
    else $error("completed frame not captured");

  a_frame_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (s1_max_q >= s1_min_q))
    else $error("frame max below frame min");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_clip_q) |-> (out_val_q == upper_limit_q))
    else $error("clipped result differs from upper limit");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import atms_pkg::*;

  localparam int FRAME_LEN      = 10;
  localparam int MEAN_SH        = 3;
  localparam int PHASES         = 8;
  localparam int FRAMES_PER_PH  = 12;
  localparam int PRESSURE_PH    = 4;
  localparam int HOLDOFF_LEN    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam longint VAL_MIN    = -(64'sd1 <<< 31);

  typedef struct packed {
    logic [RAW_W-1:0] raw_mean;
    logic [VAL_W-1:0] scaled_value;
    logic             clipped;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  atms_in_if #(.SAMPLE_BITS(12)) in_if ();
  atms_out_if                    out_if ();
  atms_cfg_if                    cfg_if ();

  adc_trimmed_mean_scaler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Stimulus and expectation stores
  logic [11:0]   sample_feed_q[$];
  frame_result_t frame_results_q[$];

  // Predictor copy of the registers and frame accumulators
  logic [1:0]               mode_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic signed [VAL_W-1:0]  lower_q;
  logic signed [VAL_W-1:0]  upper_q;
  logic [11:0]              top_q;
  logic [11:0]              bot_q;
  logic [15:0]              acc_q;
  logic [3:0]               cnt_q;

  int idle_pct      = 0;
  int stall_pct     = 0;
  int holdoff_token = 0;
  int holdoff_seen  = 0;
  int holdoff_left  = 0;
  int err_cnt       = 0;
  int quiet_cycles  = 0;
  logic sample_taken = 1'b0;

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Fold one sample into the frame; on a full frame, queue the trimmed, scaled result
  function automatic void absorb_sample(logic [11:0] s);
    logic [15:0]   rest;
    int            m;
    int            code;
    longint        prod;
    longint        val;
    longint        up;
    frame_result_t r;
    if (cnt_q == 4'd0) begin
      top_q = s;
      bot_q = s;
    end else begin
      if (s > top_q) top_q = s;
      if (s < bot_q) bot_q = s;
    end
    acc_q = acc_q + 16'(s);
    cnt_q = cnt_q + 4'd1;
    if (int'(cnt_q) < FRAME_LEN) return;

    // Drop one max and one min, or just one when the frame is flat
    rest = acc_q - 16'(top_q);
    if (top_q != bot_q) rest = rest - 16'(bot_q);
    m = int'(rest >> MEAN_SH);
    if (m <= int'(LOW_CUT)) m = (m >= int'(LOW_SUB)) ? m - int'(LOW_SUB) : 0;
    else m = m + int'(HIGH_ADD);
    if (m > int'(RAW_MAX)) m = int'(RAW_MAX);

    // Scale by mode
    case (mode_q)
      MODE_DOUBLE: prod = longint'(gain_q) * longint'(m) * 2;
      MODE_LOOP: begin
        code = (m < int'(LOOP_FLOOR)) ? 0 : m - int'(LOOP_FLOOR);
        prod = longint'(gain_q) * longint'(code);
      end
      default: prod = longint'(gain_q) * longint'(m);
    endcase

    // Round Q.24 to Q16.16, offset, clip at the top, saturate at the bottom
    val = ((prod + 128) >>> 8) + longint'(lower_q);
    up  = longint'(upper_q);
    r.clipped = 1'b0;
    if (val > up) begin
      val = up;
      r.clipped = 1'b1;
    end else if (val < VAL_MIN) begin
      val = VAL_MIN;
    end
    r.raw_mean     = RAW_W'(m);
    r.scaled_value = VAL_W'(val);
    frame_results_q.push_back(r);

    top_q = '0;
    bot_q = '0;
    acc_q = '0;
    cnt_q = '0;
  endfunction

  // Monitor: track register writes, predict on accepted samples, check results
  always @(posedge clk_i) begin
    frame_result_t want;
    logic          bad;
    if (!rst_ni) begin
      mode_q  = RST_SCALE_MODE;
      gain_q  = RST_GAIN;
      lower_q = RST_LOWER_LIMIT;
      upper_q = RST_UPPER_LIMIT;
      top_q   = '0;
      bot_q   = '0;
      acc_q   = '0;
      cnt_q   = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_SCALE_MODE:  mode_q  = cfg_if.data[1:0];
          CFG_GAIN:        gain_q  = cfg_if.data;
          CFG_LOWER_LIMIT: lower_q = cfg_if.data[VAL_W-1:0];
          CFG_UPPER_LIMIT: upper_q = cfg_if.data[VAL_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) absorb_sample(in_if.sample);
      if (out_if.valid && out_if.ready) begin
        if (frame_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result with no frame pending: raw %0d value %0d clip %0b",
                     out_if.raw_mean, $signed(out_if.scaled_value), out_if.clipped);
        end else begin
          want = frame_results_q.pop_front();
          bad  = (out_if.raw_mean !== want.raw_mean) ||
                 (out_if.scaled_value !== want.scaled_value) ||
                 (out_if.clipped !== want.clipped);
          if (bad) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("frame mismatch: want raw %0d value %0d clip %0b, got raw %0d value %0d clip %0b",
                       want.raw_mean, $signed(want.scaled_value), want.clipped,
                       out_if.raw_mean, $signed(out_if.scaled_value), out_if.clipped);
          end
        end
      end
    end
  end

  // Note sample requests taken, for the driver at the next falling edge
  always @(posedge clk_i) begin
    sample_taken <= rst_ni && in_if.valid && in_if.ready;
  end

  // Driver: advance to the next sample after a request is taken, idle at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || sample_taken) begin
      if (sample_feed_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_if.sample <= sample_feed_q.pop_front();
        in_if.valid  <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, hold off for a long stretch on request
  always @(negedge clk_i) begin
    if (holdoff_token != holdoff_seen) begin
      holdoff_seen = holdoff_token;
      holdoff_left = HOLDOFF_LEN;
    end
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic write_all(logic [1:0] mode, logic [GAIN_W-1:0] gain,
                           logic [VAL_W-1:0] lower, logic [VAL_W-1:0] upper);
    write_reg(CFG_SCALE_MODE, {38'({$urandom, $urandom}), mode});
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_LOWER_LIMIT, {8'($urandom), lower});
    write_reg(CFG_UPPER_LIMIT, {8'($urandom), upper});
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every sample is in and every frame result is out, then settle
  task automatic drain();
    while (sample_feed_q.size() != 0 || in_if.valid || frame_results_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Queue one frame of samples in one of several shapes
  task automatic queue_frame();
    int centers[14] = '{0, 1, 2, 16, 254, 256, 258, 260, 403, 406, 409, 412, 4095, -1};
    int style;
    int base;
    int flat;
    int x;
    int k;
    style = $urandom_range(0, 9);
    base  = centers[$urandom_range(0, 13)];
    if (base < 0) base = $urandom_range(0, 4095);
    flat = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4095 : 0)
                                       : $urandom_range(0, 4095);
    for (k = 0; k < FRAME_LEN; k++) begin
      case (style)
        4: x = flat;
        5, 6, 7: begin
          x = base + $urandom_range(0, 8) - 4;
          if (x < 0) x = 0;
          if (x > 4095) x = 4095;
        end
        8: x = ($urandom_range(0, 2) == 0) ? 0
             : ($urandom_range(0, 1) ? 4095 : $urandom_range(0, 4095));
        9: x = base;
        default: x = $urandom_range(0, 4095);
      endcase
      sample_feed_q.push_back(12'(x));
    end
  endtask

  initial begin
    int ph;
    int f;
    int gsmall;
    int lsmall;
    logic [GAIN_W-1:0] g;
    logic [VAL_W-1:0]  lo;
    logic [VAL_W-1:0]  hi;

    in_if.valid  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SCALE_MODE;
    cfg_if.data  = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: small mean frame with both sample extremes, then a flat full-scale frame
    sample_feed_q.push_back(12'd0);
    sample_feed_q.push_back(12'd4095);
    repeat (8) sample_feed_q.push_back(12'd1);
    repeat (FRAME_LEN) sample_feed_q.push_back(12'd4095);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_all(MODE_LINEAR, 40'd16777216, 32'd0, 32'h7FFF_FFFF);
        1: write_all(MODE_DOUBLE, 40'd25165824, 32'(-65536000), 32'd327680000);
        2: write_all(MODE_LOOP, 40'd167772, 32'd262144, 32'd1310720);
        3: write_all(2'd3, 40'h7F_FFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        4: write_all(MODE_DOUBLE, 40'h80_0000_0000, 32'h8000_0000, 32'h8000_0000);
        default: begin
          gsmall = int'($urandom_range(0, 134217728)) - 67108864;
          lsmall = int'($urandom_range(0, 2097152)) - 1048576;
          g  = $urandom_range(0, 1) ? GAIN_W'({$urandom, $urandom})
                                    : GAIN_W'(longint'(gsmall));
          lo = $urandom_range(0, 1) ? VAL_W'($urandom) : VAL_W'(lsmall);
          hi = $urandom_range(0, 1) ? VAL_W'($urandom)
                                    : VAL_W'(int'($urandom_range(0, 33554432)));
          write_all(2'($urandom_range(0, 3)), g, lo, hi);
        end
      endcase

      // Idle and stall pattern for this phase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      if (ph == PRESSURE_PH) begin
        idle_pct = 0;
        stall_pct = 0;
        holdoff_token++;
      end

      for (f = 0; f < FRAMES_PER_PH; f++) queue_frame();
      drain();
    end

    if (frame_results_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
